@@ src/gprd_pkg.sv @@
// Shared types, constants and decode functions of the gamepad report decoder.
package gprd_pkg;

  localparam int Channels = 4;
  localparam int ChW = 2;

  localparam logic [15:0] StdDevice = 16'h0900;
  localparam logic [7:0] TrigPress = 8'd170;
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusErr = 2'd1;
  localparam logic [1:0] StatusOrigin = 2'd2;
  localparam logic [1:0] RegSpec = 2'd0;
  localparam logic [1:0] RegAnalog = 2'd1;
  localparam logic [1:0] RegMask = 2'd2;

  // Work item passed from the front part to the back part.
  typedef struct packed {
    logic is_origin;
    logic [ChW-1:0] channel;
    logic [31:0] word_hi;
    logic [31:0] word_lo;
    logic [15:0] device_type;
    logic [1:0] fmt;
    logic [2:0] analog_mode;
    logic stickx_en;
  } work_t;

  typedef struct packed {
    logic [7:0] sx, sy, cx, cy, tl, tr;
  } origin_t;

  typedef struct packed {
    logic [13:0] btn;
    logic [7:0] sx, sy, cx, cy, tl, tr;
  } prev_t;

  // Result fields, packed into tdata with status in the low bits and activity at the top.
  typedef struct packed {
    logic activity;
    logic sticks_zeroed;
    logic [7:0] analog_b, analog_a, trigger_r, trigger_l;
    logic [7:0] substick_y, substick_x, stick_y, stick_x;
    logic [13:0] buttons;
    logic [1:0] status;
  } result_t;

  // Signed subtract of the origin with clamping, as two's complement bytes.
  function automatic logic [7:0] clamp_sub_s8(input logic [7:0] a, input logic [7:0] o);
    logic signed [9:0] av;
    logic signed [9:0] ov;
    begin
      av = 10'(signed'(a));
      ov = 10'(signed'(o));
      if (ov > 0 && av < ov - 10'sd128) av = ov - 10'sd128;
      if (ov < 0 && av > ov + 10'sd127) av = ov + 10'sd127;
      clamp_sub_s8 = 8'(av - ov);
    end
  endfunction

  function automatic logic [7:0] clamp_sub_u8(input logic [7:0] a, input logic [7:0] o);
    clamp_sub_u8 = (a < o) ? 8'd0 : a - o;
  endfunction

  // Magnitude of a signed byte, 0 to 128.
  function automatic logic [7:0] mag8(input logic [7:0] v);
    mag8 = v[7] ? 8'(-v) : v;
  endfunction

  function automatic logic moved(input logic [7:0] a, input logic [7:0] b,
                                 input logic [3:0] thr);
    logic [7:0] d;
    begin
      d = (a > b) ? a - b : b - a;
      moved = d >= {4'd0, thr};
    end
  endfunction

endpackage

@@ src/gprd_front.sv @@
// Front part: configuration registers, input acceptance and a two-entry queue.
module gprd_front (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [88:0] s_tdata,
  output logic q_valid,
  input  logic q_ready,
  output gprd_pkg::work_t q_item
);

  logic [2:0] analog_mode;
  logic [3:0] stickx_reset_mask;
  logic [1:0] fmt;
  gprd_pkg::work_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;
  gprd_pkg::work_t w;

  assign cfg_ready = 1'b1;

  // Configuration registers; undefined format codes keep the old format.
  always_ff @(posedge clk) begin
    if (rst) begin
      analog_mode <= 3'd3;
      stickx_reset_mask <= 4'hf;
      fmt <= 2'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        gprd_pkg::RegSpec: begin
          if (cfg_data[2:1] == 2'b00) fmt <= {1'b0, cfg_data[0]};
          else if (cfg_data[2:0] <= 3'd5) fmt <= 2'd2;
        end
        gprd_pkg::RegAnalog: analog_mode <= cfg_data[2:0];
        gprd_pkg::RegMask: stickx_reset_mask <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Classify the incoming request and snapshot the settings it needs.
  always_comb begin
    w.is_origin = s_tdata[0];
    w.channel = s_tdata[2:1];
    w.word_hi = s_tdata[34:3];
    w.word_lo = s_tdata[66:35];
    w.device_type = s_tdata[82:67];
    w.fmt = fmt;
    w.analog_mode = analog_mode;
    w.stickx_en = stickx_reset_mask[s_tdata[2:1]];
  end

  assign s_tready = (count != 2'd2);
  assign push = s_tvalid && s_tready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= w;
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ src/gprd_back.sv @@
// Back part: per-channel state, report decoding and the output register.
module gprd_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  gprd_pkg::work_t q_item,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [87:0] m_tdata
);

  gprd_pkg::origin_t org_st [gprd_pkg::Channels];
  logic [15:0] typ_st [gprd_pkg::Channels];
  gprd_pkg::prev_t prev_st [gprd_pkg::Channels];

  gprd_pkg::origin_t org, no;
  gprd_pkg::prev_t prev, r;
  logic [15:0] typ;
  logic [7:0] aa, ab;
  logic [31:0] hi, lo;
  logic [13:0] ob;
  logic [4:0] bits;
  logic special, zeroed, act;
  logic [3:0] thr;
  logic take;
  gprd_pkg::result_t res;

  assign q_ready = !m_tvalid || m_tready;
  assign take = q_valid && q_ready;
  assign hi = q_item.word_hi;
  assign lo = q_item.word_lo;
  assign org = org_st[q_item.channel];
  assign prev = prev_st[q_item.channel];
  assign typ = typ_st[q_item.channel];

  // New origin entry from an origin request.
  always_comb begin
    no.sx = hi[15:8] ^ 8'h80;
    no.sy = hi[7:0] ^ 8'h80;
    no.cx = lo[31:24];
    no.cy = lo[23:16];
    no.tl = lo[15:8];
    no.tr = lo[7:0];
    if (q_item.analog_mode == 3'd1 || q_item.analog_mode == 3'd2) begin
      no.cx[3:0] = 4'd0;
      no.cy[3:0] = 4'd0;
    end
    if (q_item.analog_mode != 3'd1 && q_item.analog_mode != 3'd3 &&
        q_item.analog_mode != 3'd4) begin
      no.tl[3:0] = 4'd0;
      no.tr[3:0] = 4'd0;
    end
    no.cx = no.cx ^ 8'h80;
    no.cy = no.cy ^ 8'h80;
    if (q_item.stickx_en && !no.sx[7] && no.sx > 8'd64 &&
        q_item.device_type == gprd_pkg::StdDevice) no.sx = 8'd0;
  end

  // Report decode.
  always_comb begin
    r = '0;
    aa = 8'd0;
    ab = 8'd0;
    zeroed = 1'b0;
    if (q_item.fmt[1] == 1'b0) begin
      if (q_item.fmt[0]) bits = {hi[25], hi[20], hi[21], hi[24], hi[23]};
      else bits = {hi[20], hi[16], hi[24], hi[21], hi[19]};
      ob = {1'b0, bits, 8'd0};
      r.tl = hi[15:8];
      r.tr = hi[7:0];
      ob[6] = r.tl >= gprd_pkg::TrigPress;
      ob[5] = r.tr >= gprd_pkg::TrigPress;
      r.btn = ob;
      r.sx = lo[23:16] ^ 8'h80;
      r.sy = lo[31:24] ^ 8'h80;
      r.cx = lo[7:0] ^ 8'h80;
      r.cy = lo[15:8] ^ 8'h80;
    end else begin
      bits = 5'd0;
      ob = 14'd0;
      r.btn = hi[29:16];
      r.sx = hi[15:8];
      r.sy = hi[7:0];
      r.cx = lo[31:24];
      r.cy = lo[23:16];
      case (q_item.analog_mode)
        3'd1: begin
          r.cx = {lo[31:28], 4'd0}; r.cy = {lo[27:24], 4'd0};
          r.tl = lo[23:16]; r.tr = lo[15:8];
          aa = {lo[7:4], 4'd0}; ab = {lo[3:0], 4'd0};
        end
        3'd2: begin
          r.cx = {lo[31:28], 4'd0}; r.cy = {lo[27:24], 4'd0};
          r.tl = {lo[23:20], 4'd0}; r.tr = {lo[19:16], 4'd0};
          aa = lo[15:8]; ab = lo[7:0];
        end
        3'd3: begin
          r.tl = lo[15:8]; r.tr = lo[7:0];
        end
        3'd4: begin
          aa = lo[15:8]; ab = lo[7:0];
        end
        default: begin
          r.tl = {lo[15:12], 4'd0}; r.tr = {lo[11:8], 4'd0};
          aa = {lo[7:4], 4'd0}; ab = {lo[3:0], 4'd0};
        end
      endcase
      r.sx = r.sx ^ 8'h80; r.sy = r.sy ^ 8'h80;
      r.cx = r.cx ^ 8'h80; r.cy = r.cy ^ 8'h80;
      if (typ == gprd_pkg::StdDevice && !r.btn[7]) begin
        zeroed = 1'b1;
        r.sx = 8'd0; r.sy = 8'd0; r.cx = 8'd0; r.cy = 8'd0;
      end else begin
        r.sx = gprd_pkg::clamp_sub_s8(r.sx, org.sx);
        r.sy = gprd_pkg::clamp_sub_s8(r.sy, org.sy);
        r.cx = gprd_pkg::clamp_sub_s8(r.cx, org.cx);
        r.cy = gprd_pkg::clamp_sub_s8(r.cy, org.cy);
        r.tl = gprd_pkg::clamp_sub_u8(r.tl, org.tl);
        r.tr = gprd_pkg::clamp_sub_u8(r.tr, org.tr);
      end
    end
  end

  // Activity against the previous report.
  always_comb begin
    special = (typ == gprd_pkg::StdDevice) && !r.btn[7];
    thr = special ? 4'd10 : 4'd3;
    act = gprd_pkg::moved(gprd_pkg::mag8(r.sx), gprd_pkg::mag8(prev.sx), thr) ||
          gprd_pkg::moved(gprd_pkg::mag8(r.sy), gprd_pkg::mag8(prev.sy), thr) ||
          gprd_pkg::moved(gprd_pkg::mag8(r.cx), gprd_pkg::mag8(prev.cx), thr) ||
          gprd_pkg::moved(gprd_pkg::mag8(r.cy), gprd_pkg::mag8(prev.cy), thr) ||
          gprd_pkg::moved(r.tl, prev.tl, thr) ||
          gprd_pkg::moved(r.tr, prev.tr, thr) || (r.btn != prev.btn);
  end

  // Result assembly.
  always_comb begin
    res = '0;
    if (hi[31]) begin
      res.status = gprd_pkg::StatusErr;
    end else begin
      res.sticks_zeroed = zeroed;
      res.activity = act;
      if (r.btn[13]) begin
        res.status = gprd_pkg::StatusOrigin;
      end else begin
        res.status = gprd_pkg::StatusOk;
        res.buttons = r.btn & ~14'h0080;
        res.stick_x = r.sx; res.stick_y = r.sy;
        res.substick_x = r.cx; res.substick_y = r.cy;
        res.trigger_l = r.tl; res.trigger_r = r.tr;
        res.analog_a = aa; res.analog_b = ab;
      end
    end
  end

  // Per-channel state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gprd_pkg::Channels; i++) begin
        org_st[i] <= '0;
        typ_st[i] <= '0;
        prev_st[i] <= '0;
      end
    end else if (take) begin
      if (q_item.is_origin) begin
        org_st[q_item.channel] <= no;
        typ_st[q_item.channel] <= q_item.device_type;
      end else if (!hi[31]) begin
        prev_st[q_item.channel] <= r;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (take) m_tvalid <= !q_item.is_origin;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) m_tdata <= {6'd0, res};
  end

endmodule

@@ src/gamepad_report_decoder.sv @@
// Top level of the gamepad report decoder.
// A request is stored in the front queue, then decoded into the output register, where
// its result waits until m_tready accepts it.
// Throughput: one request per cycle while m_tready is high; channel state updates on take.
// Origin requests give no result and update the channel calibration.
// Reset (rst, synchronous) clears calibration, device types, previous reports and
// restores spec_mode 5, analog_mode 3, stickx_reset_mask 15.
module gamepad_report_decoder (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic s_tvalid,
  output logic s_tready,
  // req_type, channel, word_hi, word_lo, device_type
  input  logic [87:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status, buttons, stick_x, stick_y, substick_x, substick_y, trigger_l,
  // trigger_r, analog_a, analog_b, sticks_zeroed, activity
  output logic [87:0] m_tdata
);

  logic q_valid, q_ready;
  gprd_pkg::work_t q_item;

  gprd_front u_front (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata({1'b0, s_tdata}),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  gprd_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule
